>>> sv/srbp_pkg.sv
// shared types and constants of the sparse row block partitioner
package srbp_pkg;

  localparam int unsigned BLOCK_SIZE_W = 16;
  localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 16'd1024;
  localparam int unsigned GROUP_IDX_W = 5;

  typedef enum logic [1:0] {
    WORD_ZERO,
    WORD_PREV,
    WORD_GROUP,
    WORD_ROW
  } srbp_word_e;

  typedef struct packed {
    logic       capture;
    logic       eval;
    logic       emit;
    logic       emit_last;
    srbp_word_e sel;
  } srbp_cmd_t;

  typedef struct packed {
    logic start;
    logic close_prev;
    logic split;
    logic exact;
    logic last;
    logic more_groups;
    logic out_free;
  } srbp_status_t;

endpackage

>>> sv/srbp_stream_if.sv
// valid/ready channel interfaces for row lengths in and block words out
interface srbp_in_if #(
  parameter int unsigned LENGTH_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] row_length;
  logic                   last_row;

  modport source (output valid, output row_length, output last_row, input ready);
  modport sink (input valid, input row_length, input last_row, output ready);
endinterface

interface srbp_out_if import srbp_pkg::*; #(
  parameter int unsigned ROW_INDEX_BITS = 32
);
  logic                      valid;
  logic                      ready;
  logic [ROW_INDEX_BITS-1:0] row_index;
  logic [GROUP_IDX_W-1:0]    group_index;
  logic                      last_of_run;

  modport source (
    output valid, output row_index, output group_index, output last_of_run, input ready
  );
  modport sink (
    input valid, input row_index, input group_index, input last_of_run, output ready
  );
endinterface

>>> sv/srbp_datapath.sv
// partitioner datapath: block state, row evaluation, group stepping and output register
module srbp_datapath import srbp_pkg::*; #(
  parameter int unsigned ROW_INDEX_BITS = 32,
  parameter int unsigned LENGTH_BITS    = 24,
  parameter int unsigned GROUP_BITS     = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [BLOCK_SIZE_W-1:0]   cfg_wdata_i,
  input  logic [LENGTH_BITS-1:0]    row_length_i,
  input  logic                      last_row_i,
  input  srbp_cmd_t                 cmd_i,
  output srbp_status_t              status_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [ROW_INDEX_BITS-1:0] row_index_o,
  output logic [GROUP_IDX_W-1:0]    group_index_o,
  output logic                      last_of_run_o
);

  localparam int unsigned MAX_W = (LENGTH_BITS > BLOCK_SIZE_W) ? LENGTH_BITS : BLOCK_SIZE_W;
  localparam int unsigned SUM_W = MAX_W + 2;
  localparam int unsigned ACC_W = SUM_W + 1;
  localparam int unsigned GW    = GROUP_BITS + 1;
  localparam logic [GW-1:0] GROUP_CAP = {1'b1, {GROUP_BITS{1'b0}}};

  logic [BLOCK_SIZE_W-1:0]   block_size_q;
  logic [BLOCK_SIZE_W-1:0]   blk;
  logic [SUM_W-1:0]          blk_s;

  logic [ROW_INDEX_BITS-1:0] row_counter_q;
  logic [ROW_INDEX_BITS-1:0] block_start_q;
  logic [SUM_W-1:0]          psum_q;
  logic                      started_q;

  logic [LENGTH_BITS-1:0]    len_q;
  logic                      last_q;
  logic [ROW_INDEX_BITS-1:0] row_q;
  logic [SUM_W-1:0]          sum0_q;
  logic [ROW_INDEX_BITS-1:0] span0_q;
  logic [ROW_INDEX_BITS-1:0] row_next;

  logic                      cp;
  logic                      span_one;
  logic                      split;
  logic                      exact;
  logic [SUM_W-1:0]          p1;

  logic                      f_start_q;
  logic                      f_cp_q;
  logic                      f_split_q;
  logic                      f_exact_q;
  logic                      f_last_q;
  logic [SUM_W-1:0]          p1_q;
  logic [GW-1:0]             grp_w_q;
  logic [ACC_W-1:0]          acc_q;

  logic                      out_valid_q;
  logic [ROW_INDEX_BITS-1:0] out_row_q;
  logic [GROUP_IDX_W-1:0]    out_grp_q;
  logic                      out_last_q;
  logic [ROW_INDEX_BITS-1:0] out_row_d;
  logic [GROUP_IDX_W-1:0]    out_grp_d;
  logic                      out_free;

  assign blk      = (block_size_q == '0) ? BLOCK_SIZE_W'(1) : block_size_q;
  assign blk_s    = SUM_W'(blk);
  assign row_next = row_counter_q + ROW_INDEX_BITS'(1);

  // close before the row when a multi-row block runs over, then judge the row alone
  assign cp       = (span0_q > ROW_INDEX_BITS'(1)) && (sum0_q > blk_s);
  assign p1       = cp ? SUM_W'(len_q) : sum0_q;
  assign span_one = cp || (span0_q == ROW_INDEX_BITS'(1));
  assign split    = span_one && (p1 > blk_s);
  assign exact    = !split && (p1 == blk_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RST;
    end else if (cfg_we_i) begin
      block_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      len_q   <= row_length_i;
      last_q  <= last_row_i;
      row_q   <= row_next;
      sum0_q  <= psum_q + SUM_W'(row_length_i);
      span0_q <= row_next - block_start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_counter_q <= '0;
      block_start_q <= '0;
      psum_q        <= '0;
      started_q     <= 1'b0;
      f_start_q     <= 1'b0;
      f_cp_q        <= 1'b0;
      f_split_q     <= 1'b0;
      f_exact_q     <= 1'b0;
      f_last_q      <= 1'b0;
      p1_q          <= '0;
      grp_w_q       <= GW'(1);
      acc_q         <= '0;
    end else if (cmd_i.eval) begin
      f_start_q <= !started_q;
      f_cp_q    <= cp;
      f_split_q <= split;
      f_exact_q <= exact;
      f_last_q  <= last_q;
      p1_q      <= p1;
      grp_w_q   <= GW'(1);
      acc_q     <= ACC_W'(blk);
      if (last_q) begin
        row_counter_q <= '0;
        block_start_q <= '0;
        psum_q        <= '0;
        started_q     <= 1'b0;
      end else begin
        row_counter_q <= row_q;
        started_q     <= 1'b1;
        if (split || exact) begin
          block_start_q <= row_q;
          psum_q        <= '0;
        end else begin
          if (cp) begin
            block_start_q <= row_q - ROW_INDEX_BITS'(1);
          end
          psum_q <= p1;
        end
      end
    end else if (cmd_i.emit && (cmd_i.sel == WORD_GROUP)) begin
      grp_w_q <= grp_w_q + GW'(1);
      acc_q   <= acc_q + ACC_W'(blk);
    end
  end

  always_comb begin
    out_row_d = row_q;
    out_grp_d = '0;
    case (cmd_i.sel)
      WORD_ZERO: out_row_d = '0;
      WORD_PREV: out_row_d = row_q - ROW_INDEX_BITS'(1);
      WORD_GROUP: begin
        out_row_d = row_q - ROW_INDEX_BITS'(1);
        out_grp_d = GROUP_IDX_W'(grp_w_q[GROUP_BITS-1:0]);
      end
      WORD_ROW: out_row_d = row_q;
      default: out_row_d = row_q;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q  <= out_row_d;
      out_grp_q  <= out_grp_d;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign status_o.start       = f_start_q;
  assign status_o.close_prev  = f_cp_q;
  assign status_o.split       = f_split_q;
  assign status_o.exact       = f_exact_q;
  assign status_o.last        = f_last_q;
  assign status_o.more_groups = (grp_w_q < GROUP_CAP) && (acc_q < ACC_W'(p1_q));
  assign status_o.out_free    = out_free;

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = out_row_q;
  assign group_index_o = out_grp_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("item written while output register still holds an untaken item");

  a_last_row_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && last_q) |=> (!started_q && (psum_q == '0) && (row_counter_q == '0)))
    else $error("block state not cleared after final row");

  a_group_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_w_q <= GROUP_CAP)
    else $error("group counter ran past the cap");
`endif

endmodule

>>> sv/srbp_ctrl.sv
// partitioner controller: accepts a row, sequences evaluation and item emission
module srbp_ctrl import srbp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output srbp_cmd_t    cmd_o,
  input  srbp_status_t status_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_PREV  = 3'd3;
  localparam logic [2:0] S_GROUP = 3'd4;
  localparam logic [2:0] S_ROW   = 3'd5;
  localparam logic [2:0] S_LAST  = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d         = state_q;
    cmd_o.capture   = 1'b0;
    cmd_o.eval      = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_last = 1'b0;
    cmd_o.sel       = WORD_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_START;
      end
      S_START: begin
        if (!status_i.start) begin
          state_d = S_PREV;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = WORD_ZERO;
          cmd_o.emit_last = !(status_i.close_prev || status_i.split ||
                              status_i.exact || status_i.last);
          state_d         = S_PREV;
        end
      end
      S_PREV: begin
        if (!status_i.close_prev) begin
          state_d = S_GROUP;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = WORD_PREV;
          cmd_o.emit_last = !(status_i.split || status_i.exact || status_i.last);
          state_d         = S_GROUP;
        end
      end
      S_GROUP: begin
        if (!status_i.split || !status_i.more_groups) begin
          state_d = S_ROW;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = WORD_GROUP;
        end
      end
      S_ROW: begin
        if (!(status_i.split || status_i.exact)) begin
          state_d = S_LAST;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = WORD_ROW;
          cmd_o.emit_last = !status_i.last;
          state_d         = S_LAST;
        end
      end
      S_LAST: begin
        if (!status_i.last) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = WORD_ROW;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/sparse_row_block_partitioner.sv
// top level of the sparse row block partitioner
// Takes one CSR row nonzero count per item on in_i (row_length, last_row) and
// returns row-block boundary items on out_o (row_index, group_index,
// last_of_run). last_of_run flags the final item produced for one input row;
// a row that opens no matrix and closes nothing gives no output item at all.
// block_size is written through cfg_we_i/cfg_wdata_i; the user writes it only
// while the block is idle, which the block does not enforce; zero acts as one.
// Per row the controller walks its fixed sequence of word classes in order:
// leading zero word, closing word of the previous block, work-group words of
// a split long row (up to 31), closing word of the row and final-row word.
// The split loop issues one group word per cycle while the output side takes
// every item.
// Reset clears row counter, open block and sum; block_size returns to 1024.
// After the final row the block state clears, so the next row begins a new
// matrix with a leading zero word.
// A stalled receiver holds the output register; the controller waits in place
// and the next row is taken only once the current one has been fully issued.
module sparse_row_block_partitioner import srbp_pkg::*; #(
  parameter int unsigned ROW_INDEX_BITS = 32,
  parameter int unsigned LENGTH_BITS    = 24,
  parameter int unsigned GROUP_BITS     = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [BLOCK_SIZE_W-1:0] cfg_wdata_i,
  srbp_in_if.sink                 in_i,
  srbp_out_if.source              out_o
);

  srbp_cmd_t    cmd;
  srbp_status_t status;
  logic         in_ready;

  srbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  srbp_datapath #(
    .ROW_INDEX_BITS (ROW_INDEX_BITS),
    .LENGTH_BITS    (LENGTH_BITS),
    .GROUP_BITS     (GROUP_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .row_length_i  (in_i.row_length),
    .last_row_i    (in_i.last_row),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .row_index_o   (out_o.row_index),
    .group_index_o (out_o.group_index),
    .last_of_run_o (out_o.last_of_run)
  );

  assign in_i.ready = in_ready;

endmodule
